// ----- sv/mtrig_pkg.sv -----
package mtrig_pkg;

  // Fixed field and register widths
  localparam int FIELD_W    = 16;
  localparam int REG_STAGES = 4;
  localparam int COUNT_W    = 48;
  localparam int REG_W      = 64;
  localparam int CFG_IDX_W  = 8;
  localparam int K_W        = 4;

  // Longest run of results from one item: trigger marker plus four samples
  localparam int BURST_MAX = REG_STAGES + 1;
  localparam int LEN_W     = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STAGE_MASKS  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STAGE_VALUES = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDE_SAMPLES = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_LIMIT = 8'd3;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_TRIG  = 2'd0,
    KIND_MATCH = 2'd1,
    KIND_LIVE  = 2'd2,
    KIND_END   = 2'd3
  } kind_t;

  // All results caused by one item
  typedef struct packed {
    logic [LEN_W-1:0]                      len;
    logic [BURST_MAX-1:0][1:0]             kind;
    logic [BURST_MAX-1:0][FIELD_W-1:0]     smp;
  } burst_t;

  // Control for the compare cells
  typedef struct packed {
    logic advance;
    logic clear;
  } cell_ctl_t;

endpackage

// ----- sv/mtrig_cell.sv -----
module mtrig_cell #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mtrig_pkg::cell_ctl_t              ctl,
  input  logic [SAMPLE_BITS-1:0]            win_sample,
  input  logic [SAMPLE_BITS-1:0]            hist_in,
  input  logic                              vld_in,
  input  logic [mtrig_pkg::FIELD_W-1:0]     stage_mask,
  input  logic [mtrig_pkg::FIELD_W-1:0]     stage_value,
  output logic [SAMPLE_BITS-1:0]            hist_r,
  output logic                              vld_r,
  output logic                              hit
);

  // Compare the window sample lined up with this stage
  assign hit = ((mtrig_pkg::FIELD_W'(win_sample) & stage_mask) == stage_value);

  // Hold the fill bit of this history place; drop it when the stage masks are rewritten
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctl.clear) begin
      vld_r <= 1'b0;
    end else if (ctl.advance) begin
      vld_r <= vld_in;
    end
  end

  // Advance the sample history one place
  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      hist_r <= hist_in;
    end
  end

endmodule

// ----- sv/mtrig_outq.sv -----
module mtrig_outq (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push,
  input  mtrig_pkg::burst_t                 push_burst,
  output logic                              full,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        out_kind,
  output logic [mtrig_pkg::FIELD_W-1:0]     out_sample,
  output logic                              out_last
);

  mtrig_pkg::burst_t               head_r, head_nxt, tail_r, tail_nxt;
  logic                            head_vld_r, head_vld_nxt, tail_vld_r, tail_vld_nxt;
  logic [mtrig_pkg::LEN_W-1:0]     pos_r, pos_nxt;
  logic                            take, at_last, head_done, head_free;

  assign take      = head_vld_r && !out_stall;
  assign at_last   = (pos_r == (head_r.len - mtrig_pkg::LEN_W'(1)));
  assign head_done = take && at_last;
  assign head_free = !head_vld_r || head_done;

  assign full       = tail_vld_r;
  assign out_valid  = head_vld_r;
  assign out_kind   = head_r.kind[pos_r];
  assign out_sample = head_r.smp[pos_r];
  assign out_last   = at_last;

  // Move bursts from tail to head as the head drains
  always_comb begin
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    head_vld_nxt = head_vld_r;
    tail_vld_nxt = tail_vld_r;
    pos_nxt      = pos_r;
    if (head_free) begin
      pos_nxt = '0;
      if (tail_vld_r) begin
        head_nxt     = tail_r;
        head_vld_nxt = 1'b1;
        tail_vld_nxt = push;
        if (push) begin
          tail_nxt = push_burst;
        end
      end else if (push) begin
        head_nxt     = push_burst;
        head_vld_nxt = 1'b1;
      end else begin
        head_vld_nxt = 1'b0;
      end
    end else begin
      if (take) begin
        pos_nxt = pos_r + mtrig_pkg::LEN_W'(1);
      end
      if (push) begin
        tail_nxt     = push_burst;
        tail_vld_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_vld_r <= 1'b0;
      tail_vld_r <= 1'b0;
      pos_r      <= '0;
    end else begin
      head_vld_r <= head_vld_nxt;
      tail_vld_r <= tail_vld_nxt;
      pos_r      <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

endmodule

// ----- sv/multistage_logic_trigger_core.sv -----
// Serial pattern trigger for a logic analyser. The block takes one sample per cycle while
// the input is not stalled and, while armed, checks it in a row of NUM_STAGES cells that
// each hold one past sample and one fill bit; every stage compares the window sample that
// lines up with it for the current depth K, so the window of the last K samples is checked
// combinationally. An item that completes the trigger gives K+1 results (marker and K
// samples), an item that reaches the limit gives two, and these occupy the output for one
// cycle per result while the output is not stalled. Results enter the output queue when the
// item is accepted and appear once earlier results are taken. The two-burst output queue
// lets a new item enter while previous results are still being taken, so the output channel
// alone sets the sustained rate; the input stalls only while a second burst waits.
module multistage_logic_trigger_core #(
  parameter int NUM_STAGES  = 4,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [mtrig_pkg::FIELD_W-1:0]       in_sample_in,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          out_kind,
  output logic [mtrig_pkg::FIELD_W-1:0]       out_sample_out,
  output logic                                out_last_of_run,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mtrig_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mtrig_pkg::REG_W-1:0]         cfg_data
);

  localparam int USABLE = (NUM_STAGES < mtrig_pkg::REG_STAGES) ? NUM_STAGES
                                                                : mtrig_pkg::REG_STAGES;
  localparam logic [SAMPLE_BITS-1:0] NARROW_MASK = SAMPLE_BITS'(8'hFF);
  localparam logic [mtrig_pkg::COUNT_W-1:0] COUNT_MAX = '1;

  // Configuration and control state
  logic [mtrig_pkg::REG_W-1:0]     masks_r, values_r;
  logic                            wide_r;
  logic [mtrig_pkg::COUNT_W-1:0]   limit_r, count_r, count_nxt;
  logic [mtrig_pkg::K_W-1:0]       k_r, k_nxt;
  logic                            fired_r, fired_nxt, finished_r, finished_nxt;

  logic                            in_accept, cfg_write, mask_write;
  logic [SAMPLE_BITS-1:0]          s_cur;
  mtrig_pkg::cell_ctl_t            ctl;

  logic [SAMPLE_BITS-1:0]          hist[NUM_STAGES];
  logic                            vld[NUM_STAGES];
  logic                            hit[NUM_STAGES];
  logic [SAMPLE_BITS-1:0]          sel[NUM_STAGES];
  logic [SAMPLE_BITS-1:0]          win[NUM_STAGES+1];

  logic                            match, at_end;
  mtrig_pkg::burst_t               burst;
  logic                            push;
  logic                            q_full;

  assign cfg_ready  = 1'b1;
  assign cfg_write  = cfg_valid && cfg_ready;
  assign mask_write = cfg_write && (cfg_index == mtrig_pkg::REG_STAGE_MASKS);
  assign in_stall   = q_full;
  assign in_accept  = in_valid && !in_stall;

  // Cut the sample to the active width
  assign s_cur = in_sample_in[SAMPLE_BITS-1:0] & (wide_r ? {SAMPLE_BITS{1'b1}} : NARROW_MASK);

  assign ctl.advance = in_accept;
  assign ctl.clear   = mask_write;

  // Row of compare cells: history and fill bits shift right
  for (genvar j = 0; j < NUM_STAGES; j++) begin : g_cell
    logic [mtrig_pkg::FIELD_W-1:0] cell_mask, cell_value;
    if (j < mtrig_pkg::REG_STAGES) begin : g_reg
      assign cell_mask  = masks_r[mtrig_pkg::FIELD_W*j +: mtrig_pkg::FIELD_W];
      assign cell_value = values_r[mtrig_pkg::FIELD_W*j +: mtrig_pkg::FIELD_W];
    end else begin : g_none
      assign cell_mask  = '0;
      assign cell_value = '0;
    end
    if (j == 0) begin : g_first
      mtrig_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .win_sample (sel[j]),
        .hist_in    (s_cur),
        .vld_in     (1'b1),
        .stage_mask (cell_mask),
        .stage_value(cell_value),
        .hist_r     (hist[j]),
        .vld_r      (vld[j]),
        .hit        (hit[j])
      );
    end else begin : g_next
      mtrig_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .win_sample (sel[j]),
        .hist_in    (hist[j-1]),
        .vld_in     (vld[j-1]),
        .stage_mask (cell_mask),
        .stage_value(cell_value),
        .hist_r     (hist[j]),
        .vld_r      (vld[j]),
        .hit        (hit[j])
      );
    end
  end

  // Window by age: the new sample, then history newest first
  always_comb begin
    win[0] = s_cur;
    for (int a = 1; a <= NUM_STAGES; a++) begin
      win[a] = hist[a-1];
    end
  end

  // Line stage j up with the sample of age K-1-j
  always_comb begin
    for (int j = 0; j < NUM_STAGES; j++) begin
      sel[j] = s_cur;
      for (int a = 0; a < NUM_STAGES; a++) begin
        if (mtrig_pkg::K_W'(a + j + 1) == k_r) begin
          sel[j] = win[a];
        end
      end
    end
  end

  // Full match: every active stage hits and the history holds K-1 samples
  always_comb begin
    match = 1'b1;
    for (int j = 0; j < NUM_STAGES; j++) begin
      if ((mtrig_pkg::K_W'(j) < k_r) && !hit[j]) begin
        match = 1'b0;
      end
      if ((mtrig_pkg::K_W'(j + 2) == k_r) && !vld[j]) begin
        match = 1'b0;
      end
    end
  end

  // Number of active stages from a new mask word
  always_comb begin
    k_nxt = mtrig_pkg::K_W'(USABLE);
    for (int j = USABLE - 1; j >= 0; j--) begin
      if (cfg_data[mtrig_pkg::FIELD_W*j +: mtrig_pkg::FIELD_W] == '0) begin
        k_nxt = mtrig_pkg::K_W'(j);
      end
    end
  end

  // Build the results of the current item and the next control state
  always_comb begin
    count_nxt    = (count_r == COUNT_MAX) ? count_r : count_r + mtrig_pkg::COUNT_W'(1);
    at_end       = (limit_r != '0) && (count_nxt >= limit_r);
    fired_nxt    = fired_r;
    finished_nxt = finished_r;
    burst        = '0;
    push         = 1'b0;
    if (finished_r) begin
      count_nxt = count_r;
    end else if (!fired_r && (k_r != '0)) begin
      count_nxt = count_r;
      if (match) begin
        push             = in_accept;
        fired_nxt        = 1'b1;
        burst.len        = mtrig_pkg::LEN_W'(k_r) + mtrig_pkg::LEN_W'(1);
        burst.kind[0]    = mtrig_pkg::KIND_TRIG;
        for (int p = 1; p < mtrig_pkg::BURST_MAX; p++) begin
          burst.kind[p] = mtrig_pkg::KIND_MATCH;
          for (int a = 0; a <= NUM_STAGES; a++) begin
            if (mtrig_pkg::K_W'(a + p) == k_r) begin
              burst.smp[p] = mtrig_pkg::FIELD_W'(win[a]);
            end
          end
        end
      end
    end else begin
      push          = in_accept;
      fired_nxt     = 1'b1;
      burst.kind[0] = mtrig_pkg::KIND_LIVE;
      burst.smp[0]  = mtrig_pkg::FIELD_W'(s_cur);
      burst.len     = mtrig_pkg::LEN_W'(1);
      if (at_end) begin
        finished_nxt  = 1'b1;
        burst.kind[1] = mtrig_pkg::KIND_END;
        burst.len     = mtrig_pkg::LEN_W'(2);
      end
    end
  end

  // Hold trigger state; take register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      masks_r    <= '0;
      values_r   <= '0;
      wide_r     <= 1'b0;
      limit_r    <= '0;
      k_r        <= '0;
      fired_r    <= 1'b1;
      finished_r <= 1'b0;
      count_r    <= '0;
    end else begin
      if (in_accept) begin
        finished_r <= finished_nxt;
        count_r    <= count_nxt;
      end
      // A new mask word re-arms the search unless its first mask field is zero
      if (mask_write) begin
        fired_r <= (cfg_data[mtrig_pkg::FIELD_W-1:0] == '0);
      end else if (in_accept) begin
        fired_r <= fired_nxt;
      end
      if (cfg_write) begin
        unique case (cfg_index)
          mtrig_pkg::REG_STAGE_MASKS: begin
            masks_r <= cfg_data;
            k_r     <= k_nxt;
          end
          mtrig_pkg::REG_STAGE_VALUES: values_r <= cfg_data;
          mtrig_pkg::REG_WIDE_SAMPLES: wide_r   <= cfg_data[0];
          mtrig_pkg::REG_SAMPLE_LIMIT: limit_r  <= cfg_data[mtrig_pkg::COUNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  mtrig_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_burst(burst),
    .full      (q_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_kind  (out_kind),
    .out_sample(out_sample_out),
    .out_last  (out_last_of_run)
  );

endmodule
